[src/pqms_pkg.sv]
// Shared types and codes for the max-scan priority queue.
`default_nettype none

package pqms_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W = 4;

  // Request codes
  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[src/priority_queue_max_scan_core.sv]
// Top level of the bounded max-scan priority queue built as a chain of cells.
// Holds up to DEPTH value/priority pairs in arrival order, one per cell. An enqueue
// writes the cell at the tail and returns its result through the done state; a full
// queue or an empty dequeue takes the same path. A successful dequeue rotates the whole
// chain once past a head comparator, closes the gap by shifting the cells from the
// winner onward, and then returns its result. One request is in flight at a time; a
// new beat is taken while the previous result still sits in the output register.
// Occupancy reports the count masked to four bits.
`default_nettype none

module priority_queue_max_scan_core #(
  parameter int unsigned DEPTH = 8
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire               req_type,
  input  wire signed [31:0] item_value,
  input  wire signed [31:0] item_priority,
  output logic              out_valid,
  input  wire               out_stall,
  output logic [1:0]        status,
  output logic signed [31:0] out_value,
  output logic signed [31:0] out_priority,
  output logic [3:0]        occupancy
);
  import pqms_pkg::*;

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_SCAN    = 2'd1;
  localparam logic [1:0] S_COMPACT = 2'd2;
  localparam logic [1:0] S_DONE    = 2'd3;

  logic [1:0]          state;
  logic [1:0]          state_next;
  logic [CW-1:0]       count;
  logic [IW-1:0]       step;
  logic [STATUS_W-1:0] res_status;
  entry_t              res_entry;

  entry_t              cell_q [DEPTH];
  cell_ctrl_t          cell_ctrl [DEPTH];
  entry_t              item;
  entry_t              best;
  logic [IW-1:0]       best_idx;

  logic in_fire;
  logic out_free;
  logic full;
  logic enq_ok;
  logic scan_first;
  logic scan_en;
  logic scan_last;

  always_comb begin
    item.value = item_value;
    item.prio  = item_priority;
    in_stall   = state != S_IDLE;
    in_fire    = in_valid && !in_stall;
    out_free   = !out_valid || !out_stall;
    full       = count == CW'(DEPTH);
    enq_ok     = in_fire && (req_type == REQ_ENQ) && !full;
    scan_first = (state == S_SCAN) && (step == '0);
    scan_en    = (state == S_SCAN) && (CW'(step) < count);
    scan_last  = step == IW'(DEPTH - 1);
  end

  // Cell chain: cell i takes cell i+1, the last one wraps to cell 0.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    always_comb begin
      cell_ctrl[i].load  = enq_ok && (count == CW'(i));
      cell_ctrl[i].shift = (state == S_SCAN) ||
                           ((state == S_COMPACT) && (IW'(i) >= best_idx));
    end

    pqms_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl[i]),
      .load_entry (item),
      .next_entry (cell_q[(i + 1) % DEPTH]),
      .entry      (cell_q[i])
    );
  end

  pqms_best #(.IW(IW)) u_best (
    .clk       (clk),
    .first     (scan_first),
    .update_en (scan_en),
    .head      (cell_q[0]),
    .pos       (step),
    .best      (best),
    .best_idx  (best_idx)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          if ((req_type == REQ_DEQ) && (count != '0)) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_next = S_COMPACT;
        end
      end
      S_COMPACT: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (enq_ok) begin
        count <= count + CW'(1);
      end else if (state == S_COMPACT) begin
        count <= count - CW'(1);
      end

      if (state == S_SCAN) begin
        step <= scan_last ? '0 : step + IW'(1);
      end

      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result staging and the output register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_entry <= '0;
      if (req_type == REQ_ENQ) begin
        res_status <= full ? ST_FULL : ST_DONE;
      end else begin
        res_status <= (count == '0) ? ST_EMPTY : ST_DONE;
      end
    end else if (state == S_COMPACT) begin
      res_entry <= best;
    end

    if (state == S_DONE && out_free) begin
      status       <= res_status;
      out_value    <= res_entry.value;
      out_priority <= res_entry.prio;
      occupancy    <= OCC_W'(count);
    end
  end

endmodule

`default_nettype wire

[src/pqms_cell.sv]
// One storage cell of the queue chain: load a new entry or take the neighbor's.
`default_nettype none

module pqms_cell (
  input  wire                 clk,
  input  pqms_pkg::cell_ctrl_t ctrl,
  input  pqms_pkg::entry_t    load_entry,
  input  pqms_pkg::entry_t    next_entry,
  output pqms_pkg::entry_t    entry
);
  import pqms_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      entry <= load_entry;
    end else if (ctrl.shift) begin
      entry <= next_entry;
    end
  end

endmodule

`default_nettype wire

[src/pqms_best.sv]
// Running winner of the dequeue scan: watches the chain head as entries rotate past.
`default_nettype none

module pqms_best #(
  parameter int unsigned IW = 3
) (
  input  wire               clk,
  input  wire               first,
  input  wire               update_en,
  input  pqms_pkg::entry_t  head,
  input  wire [IW-1:0]      pos,
  output pqms_pkg::entry_t  best,
  output logic [IW-1:0]     best_idx
);
  import pqms_pkg::*;

  logic prio_gt;
  logic prio_eq;
  logic value_gt;
  logic better;

  always_comb begin
    prio_gt  = $signed(head.prio) > $signed(best.prio);
    prio_eq  = head.prio == best.prio;
    value_gt = $signed(head.value) > $signed(best.value);
    // strict compare keeps the older entry on a full tie
    better   = prio_gt || (prio_eq && value_gt);
  end

  always_ff @(posedge clk) begin
    if (first) begin
      best     <= head;
      best_idx <= pos;
    end else if (update_en && better) begin
      best     <= head;
      best_idx <= pos;
    end
  end

endmodule

`default_nettype wire

[src/pqms_check.sv]
// Port-level checker for the priority queue core, bound to the top level.
`default_nettype none

module pqms_check #(
  parameter int unsigned DEPTH = 8
) (
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_stall,
  input wire        out_valid,
  input wire        out_stall,
  input wire [1:0]  status,
  input wire [31:0] out_value,
  input wire [31:0] out_priority,
  input wire [3:0]  occupancy
);
  import pqms_pkg::*;

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(out_value) &&
      $stable(out_priority) && $stable(occupancy))
    else $error("stalled result beat changed");

  // one request in flight: an accepted beat closes the input
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while a request is in flight");

  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_DONE) |-> (out_value == '0) && (out_priority == '0))
    else $error("failed request returned a nonzero pair");

  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_EMPTY) |-> occupancy == '0)
    else $error("empty status with nonzero occupancy");

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (DEPTH > 15) || (occupancy <= 4'(DEPTH)))
    else $error("occupancy beyond queue depth");

endmodule

bind priority_queue_max_scan_core pqms_check #(.DEPTH(DEPTH)) u_pqms_check (.*);

`default_nettype wire

[tb/tb_priority_queue_max_scan_core.sv]
// Self-checking testbench for the max-scan priority queue core.
`timescale 1ns / 100ps

module tb_priority_queue_max_scan_core;
  import pqms_pkg::*;

  localparam int QUEUE_DEPTH = 8;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 200;
  localparam int TAIL_CYCLES = QUEUE_DEPTH + 6;
  localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;

  typedef struct {
    logic              req;
    logic signed [31:0] val;
    logic signed [31:0] pri;
  } request_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic signed [31:0]  val;
    logic signed [31:0]  pri;
    logic [OCC_W-1:0]    occ;
  } response_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               req_type = REQ_ENQ;
  logic signed [31:0] item_value = '0;
  logic signed [31:0] item_priority = '0;
  logic               out_valid;
  logic               out_stall = 1'b1;
  logic [1:0]         status;
  logic signed [31:0] out_value;
  logic signed [31:0] out_priority;
  logic [3:0]         occupancy;

  priority_queue_max_scan_core #(.DEPTH(QUEUE_DEPTH)) uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .item_value   (item_value),
    .item_priority(item_priority),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .out_value    (out_value),
    .out_priority (out_priority),
    .occupancy    (occupancy)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  request_t  request_backlog[$];
  response_t pending_results[$];

  // Shadow copy of the queue contents, oldest entry at index 0
  logic signed [31:0] shadow_val[QUEUE_DEPTH];
  logic signed [31:0] shadow_pri[QUEUE_DEPTH];
  int                 shadow_count = 0;

  int  mismatches = 0;
  int  snd_idle_pct = 0;
  int  rcv_idle_pct = 0;
  int  quiet_cycles = 0;
  int  hold_left = 0;
  bit  hold_go = 1'b0;
  bit  hold_seen = 1'b0;
  bit  in_taken = 1'b0;
  request_t  drv_item;
  response_t got;
  response_t want;

  function automatic response_t serve_request(request_t r);
    response_t res;
    int        best;
    res.status = ST_DONE;
    res.val = '0;
    res.pri = '0;
    if (r.req == REQ_ENQ) begin
      if (shadow_count >= QUEUE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        shadow_val[shadow_count] = r.val;
        shadow_pri[shadow_count] = r.pri;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      best = 0;
      // Strict compares keep the oldest entry on a full tie
      for (int i = 1; i < shadow_count; i++) begin
        if (shadow_pri[i] > shadow_pri[best] ||
            (shadow_pri[i] == shadow_pri[best] && shadow_val[i] > shadow_val[best]))
          best = i;
      end
      res.val = shadow_val[best];
      res.pri = shadow_pri[best];
      for (int i = best; i + 1 < shadow_count; i++) begin
        shadow_val[i] = shadow_val[i + 1];
        shadow_pri[i] = shadow_pri[i + 1];
      end
      shadow_count--;
    end
    res.occ = shadow_count[OCC_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 200)
      $display("%0t MISMATCH %s", $time, msg);
  endtask

  // Driver: advance to the next request once the current beat is taken
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (request_backlog.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
        drv_item = request_backlog.pop_front();
        in_valid <= 1'b1;
        req_type <= drv_item.req;
        item_value <= drv_item.val;
        item_priority <= drv_item.pri;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall plus one long hold-off stretch
  always @(negedge clk) begin
    if (hold_go && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
    out_stall <= rst || hold_left != 0 || $urandom_range(99) < rcv_idle_pct;
  end

  // Monitor, predictor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      in_taken <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        got = '{status, out_value, out_priority, occupancy};
        if (pending_results.size() == 0) begin
          report_mismatch("result beat with no request outstanding");
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
          if (got.val !== want.val)
            report_mismatch($sformatf("out_value got %0d want %0d", got.val, want.val));
          if (got.pri !== want.pri)
            report_mismatch($sformatf("out_priority got %0d want %0d", got.pri, want.pri));
          if (got.occ !== want.occ)
            report_mismatch($sformatf("occupancy got %0d want %0d", got.occ, want.occ));
        end
      end
      if (in_valid && !in_stall)
        pending_results.push_back(serve_request('{req_type, item_value, item_priority}));
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
        $display("Verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic push_req(input logic req, input logic signed [31:0] val,
                          input logic signed [31:0] pri);
    request_t r;
    r.req = req;
    r.val = val;
    r.pri = pri;
    request_backlog.push_back(r);
  endtask

  // Extremes and small values often, so ties on priority and value are common
  function automatic logic signed [31:0] pick_word();
    logic signed [31:0] w;
    case ($urandom_range(9))
      0: w = INT_MIN;
      1: w = INT_MAX;
      2, 3, 4, 5: w = $signed($urandom_range(4)) - 2;
      default: w = $urandom;
    endcase
    return w;
  endfunction

  task automatic queue_random(input int count);
    int enq_pct;
    enq_pct = 50;
    for (int i = 0; i < count; i++) begin
      // Change the enqueue bias per burst so the queue swings between empty and full
      if (i % 16 == 0)
        enq_pct = 25 * $urandom_range(1, 3);
      if ($urandom_range(99) < enq_pct)
        push_req(REQ_ENQ, pick_word(), pick_word());
      else
        push_req(REQ_DEQ, $urandom, $urandom);
    end
  endtask

  task automatic wait_drained();
    while (request_backlog.size() != 0 || in_valid || pending_results.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty dequeue, fill with extremes and ties, overfill, drain, empty again
    push_req(REQ_DEQ, INT_MIN, INT_MIN);
    push_req(REQ_ENQ, 32'sd5, INT_MIN);
    push_req(REQ_ENQ, INT_MIN, INT_MAX);
    push_req(REQ_ENQ, INT_MAX, INT_MAX);
    push_req(REQ_ENQ, -32'sd1, -32'sd1);
    push_req(REQ_ENQ, 32'sd7, 32'sd3);
    push_req(REQ_ENQ, 32'sd7, 32'sd3);
    push_req(REQ_ENQ, 32'sd0, 32'sd0);
    push_req(REQ_ENQ, INT_MAX, INT_MIN);
    push_req(REQ_ENQ, 32'sd1, 32'sd1);
    for (int i = 0; i < QUEUE_DEPTH; i++)
      push_req(REQ_DEQ, (i % 2) ? INT_MAX : -32'sd1, (i % 2) ? -32'sd1 : INT_MAX);
    push_req(REQ_DEQ, INT_MAX, INT_MAX);
    wait_drained();

    snd_idle_pct = 38;
    rcv_idle_pct = 63;
    queue_random(660);
    wait_drained();

    snd_idle_pct = 63;
    rcv_idle_pct = 38;
    queue_random(660);
    wait_drained();

    // No idling; the receiver holds off early so the input backs up
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_go = 1'b1;
    queue_random(680);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
